>>> design/grsp_pkg.sv
`timescale 1ns / 1ps

package grsp_pkg;

  localparam int unsigned PktLen      = 8;
  localparam int unsigned NumSticks   = 4;
  localparam int unsigned WordW       = 13;
  localparam int unsigned DzW         = 6;
  localparam int unsigned StickW      = 7;
  localparam int unsigned IdxW        = $clog2(PktLen);

  localparam logic [7:0]        PktHeader     = 8'h80;
  localparam logic [7:0]        ReportIdOk    = 8'h01;
  localparam logic [7:0]        ReportSubOk   = 8'h00;
  localparam logic [7:0]        RawNeutral    = 8'd128;
  localparam logic [StickW-1:0] StickNeutral  = 7'd64;
  localparam logic [DzW-1:0]    DeadZoneReset = 6'd10;
  localparam logic [IdxW-1:0]   LastIdx       = IdxW'(PktLen - 1);

  typedef enum logic {
    ACT_REPORT     = 1'b0,
    ACT_DISCONNECT = 1'b1
  } action_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] report_id;
    logic [7:0] report_sub;
    logic [7:0] pad_bits_a;
    logic [7:0] pad_bits_b;
    logic [7:0] left_x;
    logic [7:0] left_y;
    logic [7:0] right_x;
    logic [7:0] right_y;
  } in_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } out_t;

  typedef logic [NumSticks-1:0][StickW-1:0] sticks_t;

  function automatic logic [WordW-1:0] map_buttons(input logic [7:0] a, input logic [7:0] b);
    logic [WordW-1:0] w;
    w = '0;
    if (a[7]) w = w | 13'h0008;
    if (a[6]) w = w | 13'h0002;
    if (a[5]) w = w | 13'h0004;
    if (a[4]) w = w | 13'h0001;
    if (a[3]) w = w | 13'h0003;
    if (a[0]) w = w | 13'h000C;
    if (b[7]) w = w | 13'h0100;
    if (b[6]) w = w | 13'h0020;
    if (b[5]) w = w | 13'h0040;
    if (b[4]) w = w | 13'h0010;
    if (b[3]) w = w | 13'h0800;
    if (b[2]) w = w | 13'h0200;
    if (b[1]) w = w | 13'h1000;
    if (b[0]) w = w | 13'h0400;
    return w;
  endfunction

endpackage

>>> design/grsp_stick_lane.sv
`timescale 1ns / 1ps

module grsp_stick_lane
  import grsp_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [7:0]        raw_i,
  input  logic [DzW-1:0]    dead_zone_i,
  output logic [StickW-1:0] stick_o
);

  logic [StickW-1:0] half;
  logic [StickW-1:0] hi_thr;
  logic [StickW:0]   lo_sum;
  logic [StickW-1:0] stick_d, stick_q;

  assign half   = raw_i[7:1];
  assign hi_thr = StickNeutral + StickW'(dead_zone_i);
  assign lo_sum = {1'b0, half} + (StickW + 1)'(dead_zone_i);

  always_comb begin
    if (half > hi_thr) begin
      stick_d = half;
    end else if (lo_sum < (StickW + 1)'(StickNeutral)) begin
      stick_d = half;
    end else begin
      stick_d = StickNeutral;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stick_q <= stick_d;
    end
  end

  assign stick_o = stick_q;

endmodule

>>> design/grsp_packet_ser.sv
`timescale 1ns / 1ps

module grsp_packet_ser
  import grsp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_valid_i,
  output logic             load_ready_o,
  input  logic [WordW-1:0] word_i,
  input  sticks_t          sticks_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_data_o
);

  logic [PktLen-1:0][7:0] pkt_d, pkt_q;
  logic                   busy_d, busy_q;
  logic [IdxW-1:0]        idx_d, idx_q;
  logic [6:0]             sum;
  logic                   take, done, load;

  // checksum over the seven leading bytes, header adds nothing below bit 7
  always_comb begin
    sum = {2'b00, word_i[12:8]} + word_i[6:0];
    for (int i = 0; i < NumSticks; i++) begin
      sum = sum + sticks_i[i];
    end
  end

  assign take         = busy_q && !out_stall_i;
  assign done         = take && (idx_q == LastIdx);
  assign load_ready_o = !busy_q || done;
  assign load         = load_valid_i && load_ready_o;

  always_comb begin
    pkt_d  = pkt_q;
    busy_d = busy_q;
    idx_d  = idx_q;
    if (take) begin
      idx_d = idx_q + IdxW'(1);
    end
    if (done) begin
      busy_d = 1'b0;
    end
    if (load) begin
      busy_d   = 1'b1;
      idx_d    = '0;
      pkt_d[0] = PktHeader;
      pkt_d[1] = {3'b000, word_i[12:8]};
      pkt_d[2] = word_i[7:0];
      for (int i = 0; i < NumSticks; i++) begin
        pkt_d[3 + i] = {1'b0, sticks_i[i]};
      end
      pkt_d[PktLen-1] = {1'b0, sum};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pkt_q <= pkt_d;
  end

  assign out_valid_o            = busy_q;
  assign out_data_o.packet_byte = pkt_q[idx_q];
  assign out_data_o.last_byte   = (idx_q == LastIdx);

  a_header_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && idx_q == '0 |-> out_data_o.packet_byte == PktHeader)
    else $error("packet does not open with header");

  a_sum_7bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last_byte |-> out_data_o.packet_byte[7] == 1'b0)
    else $error("checksum byte has top bit set");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && busy_q |-> done)
    else $error("packet overwritten while in flight");

  a_idx_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && out_stall_i |=> idx_q == $past(idx_q))
    else $error("byte index moved under stall");

endmodule

>>> design/gamepad_report_to_servo_packet.sv
`timescale 1ns / 1ps
// channel | signals                              | request
// --------+--------------------------------------+-----------------------------------
// in      | in_valid_i, in_stall_o, in_data_i    | one gamepad report or disconnect
// out     | out_valid_o, out_stall_i, out_data_o | one packet byte, eight per packet
// cfg     | cfg_we_i, cfg_wdata_i                | dead zone write
//
// an accepted request is mapped by four stick lanes into registers, then loaded into the
// packet buffer, which sends one byte per cycle while out_stall_i is low. the next request
// is taken while a packet is still going out.
// reset clears valid state and sets the dead zone to 10. rejected reports leave no packet.
// out_stall_i holds the current byte; in_stall_o rises when a full lane stage cannot load.

module gamepad_report_to_servo_packet
  import grsp_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  in_t            in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output out_t           out_data_o,
  input  logic           cfg_we_i,
  input  logic [DzW-1:0] cfg_wdata_i
);

  logic [DzW-1:0]   dead_zone_q;
  logic             stage_valid_d, stage_valid_q;
  logic [WordW-1:0] word_d, word_q;
  logic             in_take, ser_ready, keep;
  logic             is_disc;
  logic [NumSticks-1:0][7:0] raw;
  sticks_t          sticks;

  assign is_disc    = (in_data_i.action == ACT_DISCONNECT);
  assign in_stall_o = stage_valid_q && !ser_ready;
  assign in_take    = in_valid_i && !in_stall_o;
  assign keep       = is_disc || (in_data_i.report_id == ReportIdOk &&
                                  in_data_i.report_sub == ReportSubOk);

  always_comb begin
    if (is_disc) begin
      raw    = {NumSticks{RawNeutral}};
      word_d = '0;
    end else begin
      raw    = {in_data_i.left_x, in_data_i.left_y, in_data_i.right_x, in_data_i.right_y};
      word_d = map_buttons(in_data_i.pad_bits_a, in_data_i.pad_bits_b);
    end
  end

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (stage_valid_q && ser_ready) begin
      stage_valid_d = 1'b0;
    end
    if (in_take) begin
      stage_valid_d = keep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      dead_zone_q   <= DeadZoneReset;
    end else begin
      stage_valid_q <= stage_valid_d;
      if (cfg_we_i) begin
        dead_zone_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      word_q <= word_d;
    end
  end

  // lane order: left x, left y, right x, right y
  for (genvar g = 0; g < NumSticks; g++) begin : g_lane
    grsp_stick_lane u_lane (
      .clk_i       (clk_i),
      .en_i        (in_take),
      .raw_i       (raw[NumSticks-1-g]),
      .dead_zone_i (dead_zone_q),
      .stick_o     (sticks[g])
    );
  end

  grsp_packet_ser u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (stage_valid_q),
    .load_ready_o (ser_ready),
    .word_i       (word_q),
    .sticks_i     (sticks),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_valid_q && !ser_ready |=> stage_valid_q && $stable(word_q))
    else $error("lane stage lost a waiting request");

  a_reject_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && !keep |=> !stage_valid_q)
    else $error("rejected report entered lane stage");

  a_disc_neutral: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && is_disc |=> word_q == '0)
    else $error("disconnect left buttons set");

endmodule
